[hdl/gsls_pkg.sv]
// Package for the gamepad serial latch shifter.
// Holds the shared constants and the control struct that the shift cells take.
// No dependencies.

package gsls_pkg;

	// Number of button bits captured at a fall of the latch.
	localparam int unsigned SnapW = 12;

	// Length of the serial stream: snapshot bits followed by signature zeros.
	localparam int unsigned SerLen = 16;

	// Positions of the direction buttons inside the button word.
	localparam int unsigned BitUp    = 4;
	localparam int unsigned BitDown  = 5;
	localparam int unsigned BitLeft  = 6;
	localparam int unsigned BitRight = 7;

	// Bit that is shifted in once the stream is exhausted.
	localparam logic FillBit = 1'b1;

	// Control that every shift cell sees in a cycle.
	typedef struct packed {
		logic load;   // capture a new snapshot bit
		logic shift;  // take the neighbour's bit
	} cell_ctl_t;

endpackage

[hdl/gsls_cell.sv]
// One cell of the serial shift chain: holds one bit of the output stream.
// Depends on gsls_pkg for the cell control struct.

module gsls_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  gsls_pkg::cell_ctl_t ctl,
	input  logic                load_bit,
	input  logic                next_bit,
	output logic                bit_q
);

	// A load wins over a shift; the two never coincide in practice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.load) begin
			bit_q <= load_bit;
		end else if (ctl.shift) begin
			bit_q <= next_bit;
		end
	end

endmodule

[hdl/gsls_snap.sv]
// Snapshot builder: applies the opposing-direction rule to the buttons at a fall
// of the latch and keeps the previous direction bits and the two hold flags.
// Depends on gsls_pkg for the button positions.

module gsls_snap (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fall,
	input  logic [gsls_pkg::SnapW-1:0] buttons,
	output logic [gsls_pkg::SnapW-1:0] snap
);

	logic up_q, down_q, left_q, right_q;
	logic vhold_q, hhold_q;
	logic b_up, b_down, b_left, b_right;
	logic n_up, n_down, n_left, n_right;
	logic n_vhold, n_hhold;

	assign b_up    = buttons[gsls_pkg::BitUp];
	assign b_down  = buttons[gsls_pkg::BitDown];
	assign b_left  = buttons[gsls_pkg::BitLeft];
	assign b_right = buttons[gsls_pkg::BitRight];

	// Vertical axis: follow the buttons, swap once on a conflict, then hold.
	always_comb begin
		n_vhold = vhold_q;
		n_up    = up_q;
		n_down  = down_q;
		priority if (!(b_up && b_down)) begin
			n_vhold = 1'b0;
			n_up    = b_up;
			n_down  = b_down;
		end else if (!vhold_q) begin
			n_vhold = 1'b1;
			n_up    = down_q;
			n_down  = up_q;
		end else begin
			n_vhold = vhold_q;
		end
	end

	// Horizontal axis: same rule as the vertical one.
	always_comb begin
		n_hhold = hhold_q;
		n_left  = left_q;
		n_right = right_q;
		priority if (!(b_left && b_right)) begin
			n_hhold = 1'b0;
			n_left  = b_left;
			n_right = b_right;
		end else if (!hhold_q) begin
			n_hhold = 1'b1;
			n_left  = right_q;
			n_right = left_q;
		end else begin
			n_hhold = hhold_q;
		end
	end

	// New snapshot: plain buttons with the direction bits replaced.
	always_comb begin
		snap = buttons;
		snap[gsls_pkg::BitUp]    = n_up;
		snap[gsls_pkg::BitDown]  = n_down;
		snap[gsls_pkg::BitLeft]  = n_left;
		snap[gsls_pkg::BitRight] = n_right;
	end

	// Direction history and hold flags change only at a fall of the latch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q    <= 1'b0;
			down_q  <= 1'b0;
			left_q  <= 1'b0;
			right_q <= 1'b0;
			vhold_q <= 1'b0;
			hhold_q <= 1'b0;
		end else if (fall) begin
			up_q    <= n_up;
			down_q  <= n_down;
			left_q  <= n_left;
			right_q <= n_right;
			vhold_q <= n_vhold;
			hhold_q <= n_hhold;
		end
	end

endmodule

[hdl/gamepad_serial_latch_shifter_top.sv]
// Top level of the gamepad serial latch shifter.
// Depends on gsls_pkg, gsls_snap and gsls_cell.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   command, latch_level, buttons
//   output    out_valid / out_stall serial_bit
//
// One item is accepted per cycle unless the input stalls; a read
// delivers its bit in the following cycle from the output register. A latch write gives no result.
// The stream lives in a chain of sixteen one-bit cells that is loaded at a
// fall of the latch and shifts once per read while the latch is low,
// filling with ones at the end. Reset clears the latch, the chain, the
// hold flags and the output register. The input stalls only while a
// result waits in the output register and the output side is stalling.

module gamepad_serial_latch_shifter_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic                       latch_level,
	input  logic [gsls_pkg::SnapW-1:0] buttons,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       serial_bit
);

	logic                        latch_q;
	logic                        out_valid_q;
	logic                        serial_bit_q;
	logic                        accept;
	logic                        rd;
	logic                        fall;
	logic [gsls_pkg::SnapW-1:0]  snap;
	logic [gsls_pkg::SerLen-1:0] chain;
	gsls_pkg::cell_ctl_t         ctl;

	// Handshake on the input side.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign rd       = accept && command;
	assign fall     = accept && !command && !latch_level && latch_q;

	// Chain control: load at a fall, shift on a read while the latch is low.
	assign ctl.load  = fall;
	assign ctl.shift = rd && !latch_q;

	// Latch line level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
		end else if (accept && !command) begin
			latch_q <= latch_level;
		end
	end

	gsls_snap u_snap (
		.clk     (clk),
		.arst_n  (arst_n),
		.fall    (fall),
		.buttons (buttons),
		.snap    (snap)
	);

	// Row of shift cells; cell zero feeds the data line.
	for (genvar i = 0; i < gsls_pkg::SerLen; i++) begin : g_cell
		logic load_bit;
		logic next_bit;

		if (i < gsls_pkg::SnapW) begin : g_load
			assign load_bit = snap[i];
		end else begin : g_sig
			assign load_bit = 1'b0;
		end

		if (i == gsls_pkg::SerLen - 1) begin : g_last
			assign next_bit = gsls_pkg::FillBit;
		end else begin : g_mid
			assign next_bit = chain[i+1];
		end

		gsls_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.load_bit (load_bit),
			.next_bit (next_bit),
			.bit_q    (chain[i])
		);
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output data: live B while the latch is high, else the head of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_bit_q <= 1'b0;
		end else if (rd) begin
			serial_bit_q <= latch_q ? buttons[0] : chain[0];
		end
	end

	assign out_valid  = out_valid_q;
	assign serial_bit = serial_bit_q;

endmodule

[hdl/gsls_checker.sv]
// Port-level checker for the gamepad serial latch shifter, with its bind.
// Depends only on the ports of gamepad_serial_latch_shifter_top.

module gsls_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic command,
	input logic out_valid,
	input logic out_stall,
	input logic serial_bit
);

	// A pending result keeps its valid while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	// A stalled result keeps its bit.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(serial_bit))
		else $error("stalled result item changed");

	// The input stalls only behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// An accepted read yields a result in the next cycle.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command |=> out_valid)
		else $error("read item gave no result");

	// A latch write on an empty output gives no result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !command && !(out_valid && out_stall) |=> !out_valid)
		else $error("latch write item produced a result");

endmodule

bind gamepad_serial_latch_shifter_top gsls_checker u_gsls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.command    (command),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.serial_bit (serial_bit)
);

[tb/tb_gamepad_serial_latch_shifter_top.sv]
// Self-checking testbench for the gamepad serial latch shifter top level.
// Holds a scoreboard class that predicts each serial bit and the top module that drives the block.
// Depends on gsls_pkg and gamepad_serial_latch_shifter_top.

// Predicts the serial data line from the accepted items and checks each returned bit.
class serial_scoreboard;
	localparam bit CmdLatch = 1'b0;

	bit        latched;
	bit [4:0]  stream_pos;
	bit [11:0] snapshot;
	bit        vert_hold;
	bit        horiz_hold;
	bit        bits_due[$];
	int        errors;
	int        reads;
	int        writes;
	int        conflicts;
	int        checked;

	// Prints one line per mismatch and counts it.
	task report(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Opposing-direction rule for one axis of a fresh snapshot.
	function bit [11:0] resolve_axis(bit [11:0] snap, bit [11:0] btn, int p, int q,
			inout bit hold);
		bit op;
		bit oq;
		op = snap[p];
		oq = snap[q];
		if (!(btn[p] && btn[q])) begin
			hold = 1'b0;
			snap[p] = btn[p];
			snap[q] = btn[q];
		end else if (!hold) begin
			hold = 1'b1;
			snap[p] = oq;
			snap[q] = op;
		end
		return snap;
	endfunction

	// Updates the predicted state for one accepted item and queues its bit, if any.
	task note_item(bit cmd, bit lvl, bit [11:0] btn);
		bit [11:0] dir_mask;
		bit [11:0] fresh;
		dir_mask = '0;
		dir_mask[gsls_pkg::BitUp]    = 1'b1;
		dir_mask[gsls_pkg::BitDown]  = 1'b1;
		dir_mask[gsls_pkg::BitLeft]  = 1'b1;
		dir_mask[gsls_pkg::BitRight] = 1'b1;
		if (cmd == CmdLatch) begin
			writes++;
			if (lvl != latched) begin
				latched = lvl;
				stream_pos = '0;
				if (!lvl) begin
					if ((btn[gsls_pkg::BitUp] && btn[gsls_pkg::BitDown]) ||
							(btn[gsls_pkg::BitLeft] && btn[gsls_pkg::BitRight]))
						conflicts++;
					fresh = (btn & ~dir_mask) | (snapshot & dir_mask);
					fresh = resolve_axis(fresh, btn, gsls_pkg::BitUp, gsls_pkg::BitDown,
						vert_hold);
					fresh = resolve_axis(fresh, btn, gsls_pkg::BitLeft, gsls_pkg::BitRight,
						horiz_hold);
					snapshot = fresh;
				end
			end
		end else begin
			reads++;
			if (latched) begin
				bits_due.push_back(btn[0]);
			end else if (stream_pos < gsls_pkg::SnapW) begin
				bits_due.push_back(snapshot[stream_pos]);
				stream_pos++;
			end else if (stream_pos < gsls_pkg::SerLen) begin
				bits_due.push_back(1'b0);
				stream_pos++;
			end else begin
				bits_due.push_back(gsls_pkg::FillBit);
				stream_pos = 5'(gsls_pkg::SerLen);
			end
		end
	endtask

	// Compares one returned bit with the oldest prediction.
	task check_bit(logic got);
		bit want;
		if (bits_due.size() == 0) begin
			report($sformatf("serial_bit %b returned with no read outstanding", got));
		end else begin
			want = bits_due.pop_front();
			checked++;
			if (got !== want)
				report($sformatf("serial_bit %b, predicted %b", got, want));
		end
	endtask

	function int pending();
		return bits_due.size();
	endfunction
endclass

module tb_gamepad_serial_latch_shifter_top;

	localparam bit CmdLatch = 1'b0;
	localparam bit CmdRead  = 1'b1;
	localparam int ItemTarget = 1150;
	localparam int GapPct = 34;
	localparam int unsigned SnapW  = gsls_pkg::SnapW;
	localparam int unsigned SerLen = gsls_pkg::SerLen;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              command;
	logic              latch_level;
	logic [SnapW-1:0]  buttons;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              serial_bit;

	bit sender_gaps = 1'b0;
	bit receiver_gaps = 1'b0;
	int items_sent = 0;
	int drains = 0;

	serial_scoreboard scoreboard = new;

	gamepad_serial_latch_shifter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.latch_level(latch_level),
		.buttons    (buttons),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.serial_bit (serial_bit)
	);

	// Clock with a period of two units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver back-pressure, changed only at the rising edge.
	always @(posedge clk) begin
		out_stall <= receiver_gaps && ($urandom_range(99) < GapPct);
	end

	// Output side: a bit seen valid and unstalled mid-cycle is taken at the next edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			scoreboard.check_bit(serial_bit);
	end

	// Offers one item, holds it through any stall and notes it once it is taken.
	task send_item(bit cmd, bit lvl, logic [SnapW-1:0] btn);
		bit taken;
		while (sender_gaps && ($urandom_range(99) < GapPct)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		latch_level <= lvl;
		buttons     <= btn;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (!in_stall) begin
				scoreboard.note_item(cmd, lvl, btn);
				taken = 1'b1;
			end
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Holds the sender back until every predicted bit has been returned.
	task drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (scoreboard.pending() != 0)
			@(posedge clk);
		drains++;
	endtask

	// Button word that often presses both directions of an axis.
	function logic [SnapW-1:0] pick_buttons();
		logic [SnapW-1:0] btn;
		btn = SnapW'($urandom);
		if ($urandom_range(99) < 40) begin
			btn[gsls_pkg::BitUp]   = 1'b1;
			btn[gsls_pkg::BitDown] = 1'b1;
		end
		if ($urandom_range(99) < 40) begin
			btn[gsls_pkg::BitLeft]  = 1'b1;
			btn[gsls_pkg::BitRight] = 1'b1;
		end
		return btn;
	endfunction

	// One full poll: raise the latch, maybe read live B, drop the latch, shift out.
	task poll_frame();
		int live_reads;
		int shifts;
		live_reads = $urandom_range(2);
		shifts = ($urandom_range(99) < 80) ? $urandom_range(10, 20) : $urandom_range(5);
		send_item(CmdLatch, 1'b1, SnapW'($urandom));
		repeat (live_reads) send_item(CmdRead, 1'b0, SnapW'($urandom));
		send_item(CmdLatch, 1'b0, pick_buttons());
		for (int i = 0; i < shifts; i++) begin
			// A repeated low write now and then must leave the stream alone.
			if ($urandom_range(99) < 5)
				send_item(CmdLatch, 1'b0, SnapW'($urandom));
			send_item(CmdRead, 1'b0, SnapW'($urandom));
		end
	endtask

	// Stimulus.
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = CmdLatch;
		latch_level = 1'b0;
		buttons     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;

		// Directed: repeated level, live reads, a fall with both axes in conflict,
		// then the whole stream into the saturated tail.
		send_item(CmdLatch, 1'b0, 12'hFFF);
		send_item(CmdLatch, 1'b1, 12'h000);
		send_item(CmdRead, 1'b0, 12'h001);
		send_item(CmdRead, 1'b1, 12'hFFE);
		send_item(CmdLatch, 1'b1, 12'hFFF);
		send_item(CmdLatch, 1'b0, 12'hFFF);
		for (int i = 0; i < SerLen + 1; i++)
			send_item(CmdRead, 1'b0, 12'hFFF);
		drain_results();

		// Random polls with some noise; a stretch in the middle runs without gaps.
		while (items_sent < ItemTarget) begin
			sender_gaps   = !(items_sent >= 400 && items_sent < 600);
			receiver_gaps = sender_gaps;
			if ($urandom_range(99) < 85) begin
				poll_frame();
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(1'($urandom), 1'($urandom), SnapW'($urandom));
			end
			if ($urandom_range(99) < 8)
				drain_results();
		end

		// Wind down and let the last bits come out.
		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d items: %0d reads, %0d latch writes, %0d falls with a d-pad conflict.",
			items_sent, scoreboard.reads, scoreboard.writes, scoreboard.conflicts);
		$display("Checked %0d serial bits; sender paused for an empty pipe %0d times.",
			scoreboard.checked, drains);
		if (scoreboard.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[gamepad_serial_latch_shifter_top.f]
hdl/gsls_pkg.sv
hdl/gsls_cell.sv
hdl/gsls_snap.sv
hdl/gamepad_serial_latch_shifter_top.sv
hdl/gsls_checker.sv
tb/tb_gamepad_serial_latch_shifter_top.sv
